@@ design/mlfq_task_scheduler_defines.svh @@
// Assertion macros shared by the scheduler modules.
// Each expects clk and arst_n in the scope where it is used.
`ifndef MLFQ_TASK_SCHEDULER_DEFINES_SVH
`define MLFQ_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define MTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MTS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/mts_pkg.sv @@
package mts_pkg;

	localparam int NumLevels = 4;
	localparam int NumTasks  = 16;
	localparam int LvlW      = $clog2(NumLevels);
	localparam int TidW      = $clog2(NumTasks);
	localparam int CntW      = $clog2(NumTasks + 1);
	localparam int FlagW     = 3;
	localparam int TickW     = 32;
	localparam int CfgW      = 16;

	localparam logic [LvlW-1:0] TopLevel = LvlW'(NumLevels - 1);
	localparam logic [CfgW-1:0] DefTimeslice     = 16'd1;
	localparam logic [CfgW-1:0] DefBoostInterval = 16'd10;

	// Task flag bits
	localparam int FlagQueued  = 0;
	localparam int FlagBlocked = 1;
	localparam int FlagIdle    = 2;
	localparam logic [FlagW-1:0] QueuedMask  = 3'b001;
	localparam logic [FlagW-1:0] BlockedMask = 3'b010;
	localparam logic [FlagW-1:0] IdleMask    = 3'b100;

	// Input item layout in s_tdata
	localparam int InOpLsb   = 0;
	localparam int InTidLsb  = 3;
	localparam int InRlLsb   = 7;
	localparam int InIdleBit = 11;
	localparam int InUsedLsb = 12;
	localparam int InBlkBit  = 28;
	localparam int InDataW   = 32;
	localparam int OutDataW  = 16;

	typedef enum logic [2:0] {
		OP_ADD         = 3'd0,
		OP_REMOVE      = 3'd1,
		OP_PICK        = 3'd2,
		OP_REQUEUE     = 3'd3,
		OP_SET_BLOCKED = 3'd4,
		OP_TICK        = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		REG_TIMESLICE      = 2'd0,
		REG_BOOST_INTERVAL = 2'd1,
		REG_BOOST_ENABLE   = 2'd2
	} reg_idx_t;

	// Commands to the queue table unit
	typedef enum logic [1:0] {
		TB_NOP,
		TB_UNLINK,
		TB_APPEND,
		TB_SET_FLAGS
	} tb_op_t;

	typedef struct packed {
		tb_op_t            op;
		logic [TidW-1:0]   tid;
		logic [LvlW-1:0]   lv;
		logic [FlagW-1:0]  flags;
	} tb_cmd_t;

	typedef struct packed {
		logic [FlagW-1:0]  flags;
		logic [LvlW-1:0]   prio;
		logic [TidW-1:0]   next;
		logic [CntW-1:0]   count;
		logic [TidW-1:0]   head;
	} tb_rd_t;

endpackage

@@ design/mts_table.sv @@
`include "mlfq_task_scheduler_defines.svh"

module mts_table
	import mts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  tb_cmd_t cmd,
	output tb_rd_t  rd
);

	logic [FlagW-1:0] flags_q [NumTasks];
	logic [LvlW-1:0]  prio_q  [NumTasks];
	logic [TidW-1:0]  next_q  [NumTasks];
	logic [TidW-1:0]  prev_q  [NumTasks];
	logic [TidW-1:0]  head_q  [NumLevels];
	logic [TidW-1:0]  tail_q  [NumLevels];
	logic [CntW-1:0]  count_q [NumLevels];

	logic [LvlW-1:0] lvl_a;
	logic [TidW-1:0] t_next;
	logic [TidW-1:0] t_prev;
	logic [TidW-1:0] lv_head;
	logic [TidW-1:0] lv_tail;
	logic [CntW-1:0] lv_count;

	// Unlink works on the task's own level, everything else on the given one
	always_comb begin
		lvl_a    = (cmd.op == TB_UNLINK) ? prio_q[cmd.tid] : cmd.lv;
		t_next   = next_q[cmd.tid];
		t_prev   = prev_q[cmd.tid];
		lv_head  = head_q[lvl_a];
		lv_tail  = tail_q[lvl_a];
		lv_count = count_q[lvl_a];
		rd.flags = flags_q[cmd.tid];
		rd.prio  = prio_q[cmd.tid];
		rd.next  = t_next;
		rd.count = lv_count;
		rd.head  = lv_head;
	end

	// Flags and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumTasks; i++) flags_q[i] <= '0;
			for (int j = 0; j < NumLevels; j++) count_q[j] <= '0;
		end else begin
			case (cmd.op)
				TB_UNLINK: begin
					if (lv_count != '0) count_q[lvl_a] <= lv_count - 1'b1;
					flags_q[cmd.tid] <= rd.flags & ~QueuedMask;
				end
				TB_APPEND: begin
					count_q[lvl_a]   <= lv_count + 1'b1;
					flags_q[cmd.tid] <= cmd.flags | QueuedMask;
				end
				TB_SET_FLAGS: flags_q[cmd.tid] <= cmd.flags;
				default: ;
			endcase
		end
	end

	// Links, heads, tails and levels
	always_ff @(posedge clk) begin
		case (cmd.op)
			TB_UNLINK: begin
				if (lv_head == cmd.tid) head_q[lvl_a] <= t_next;
				else next_q[t_prev] <= t_next;
				if (lv_tail == cmd.tid) tail_q[lvl_a] <= t_prev;
				else prev_q[t_next] <= t_prev;
			end
			TB_APPEND: begin
				if (lv_count == '0) begin
					head_q[lvl_a] <= cmd.tid;
				end else begin
					next_q[lv_tail] <= cmd.tid;
					prev_q[cmd.tid] <= lv_tail;
				end
				tail_q[lvl_a]   <= cmd.tid;
				prio_q[cmd.tid] <= lvl_a;
			end
			default: ;
		endcase
	end

	// Totals for checking
	logic [NumTasks-1:0]  queued_vec;
	logic [CntW+LvlW-1:0] cnt_sum;

	always_comb begin
		cnt_sum = '0;
		for (int i = 0; i < NumTasks; i++) queued_vec[i] = flags_q[i][FlagQueued];
		for (int j = 0; j < NumLevels; j++) cnt_sum = cnt_sum + (CntW+LvlW)'(count_q[j]);
	end

	`MTS_ASSERT_IMP(a_count_matches, 1'b1, cnt_sum == (CntW+LvlW)'($countones(queued_vec)), "queue counts disagree with queued flags")
	`MTS_ASSERT_IMP(a_append_free, cmd.op == TB_APPEND, !rd.flags[FlagQueued], "append of a queued task")
	`MTS_ASSERT_IMP(a_unlink_queued, cmd.op == TB_UNLINK, rd.flags[FlagQueued] && (lv_count != '0), "unlink of a task not queued")

endmodule

@@ design/mts_seq.sv @@
`include "mlfq_task_scheduler_defines.svh"

module mts_seq
	import mts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,
	input  logic [CfgW-1:0]     timeslice,
	input  logic [CfgW-1:0]     boost_period,
	input  logic                boost_enable,
	output tb_cmd_t             cmd,
	input  tb_rd_t              rd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REQ_APP,
		ST_PICK_LVL,
		ST_PICK_TASK,
		ST_BOOST_LVL,
		ST_BOOST_UNL,
		ST_BOOST_APP,
		ST_DONE
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [TidW-1:0]     tid_q;
	logic [3:0]          rl_q;
	logic                idle_in_q;
	logic [CfgW-1:0]     used_q;
	logic                blk_q;
	logic [LvlW-1:0]     lv_q;
	logic [TidW-1:0]     cur_q;
	logic [TidW-1:0]     nx_q;
	logic [CntW-1:0]     k_q;
	logic                res_ok_q;
	logic [TidW-1:0]     res_pick_q;
	logic [LvlW-1:0]     res_lvl_q;
	logic [CntW-1:0]     res_moved_q;
	logic [TickW-1:0]    tick_q;
	logic [TickW-1:0]    last_q;
	logic                m_tvalid_q;
	logic [OutDataW-1:0] m_tdata_q;

	logic            queued;
	logic            blkd;
	logic            idle;
	logic [LvlW-1:0] lv_add;
	logic [LvlW-1:0] lv_req;
	logic [TickW-1:0] tick_diff;
	logic            boost_due;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Decode the current task entry and the level choices
	always_comb begin
		queued = rd.flags[FlagQueued];
		blkd   = rd.flags[FlagBlocked];
		idle   = rd.flags[FlagIdle];
		if (rl_q[3]) lv_add = '0;
		else if (rl_q > 4'(NumLevels - 1)) lv_add = TopLevel;
		else lv_add = LvlW'(rl_q);
		lv_req = (rd.prio > TopLevel) ? TopLevel : rd.prio;
		if ((used_q >= timeslice) && (lv_req != '0)) lv_req = lv_req - 1'b1;
		tick_diff = tick_q - last_q;
		boost_due = boost_enable && (tick_diff != '1) &&
			(tick_diff >= TickW'(boost_period));
	end

	// Drive the queue table
	always_comb begin
		cmd.op    = TB_NOP;
		cmd.tid   = tid_q;
		cmd.lv    = lv_q;
		cmd.flags = '0;
		case (state_q)
			ST_EXEC: begin
				case (op_q)
					OP_ADD: if (!queued) begin
						cmd.op    = TB_APPEND;
						cmd.lv    = lv_add;
						cmd.flags = idle_in_q ? IdleMask : '0;
					end
					OP_REMOVE: if (queued) cmd.op = TB_UNLINK;
					OP_SET_BLOCKED: if (queued) begin
						cmd.op    = TB_SET_FLAGS;
						cmd.flags = (rd.flags & ~BlockedMask) | (blk_q ? BlockedMask : '0);
					end
					default: ;
				endcase
			end
			ST_REQ_APP: begin
				cmd.op    = TB_APPEND;
				cmd.flags = (rd.flags & IdleMask) | (blk_q ? BlockedMask : '0);
			end
			ST_PICK_TASK: begin
				cmd.tid = cur_q;
				if (!blkd) cmd.op = TB_UNLINK;
			end
			ST_BOOST_UNL: begin
				cmd.tid = cur_q;
				if (!idle) cmd.op = TB_UNLINK;
			end
			ST_BOOST_APP: begin
				cmd.op    = TB_APPEND;
				cmd.tid   = cur_q;
				cmd.lv    = TopLevel;
				cmd.flags = rd.flags;
			end
			default: ;
		endcase
	end

	// Sequence one item at a time and hold its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			tick_q      <= '0;
			last_q      <= '0;
			op_q        <= OP_ADD;
			tid_q       <= '0;
			rl_q        <= '0;
			idle_in_q   <= 1'b0;
			used_q      <= '0;
			blk_q       <= 1'b0;
			lv_q        <= '0;
			cur_q       <= '0;
			nx_q        <= '0;
			k_q         <= '0;
			res_ok_q    <= 1'b0;
			res_pick_q  <= '0;
			res_lvl_q   <= '0;
			res_moved_q <= '0;
		end else begin
			// Drop the result once taken, unless a new one is loaded now
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q        <= op_t'(s_tdata[InOpLsb +: 3]);
						tid_q       <= s_tdata[InTidLsb +: TidW];
						rl_q        <= s_tdata[InRlLsb +: 4];
						idle_in_q   <= s_tdata[InIdleBit];
						used_q      <= s_tdata[InUsedLsb +: CfgW];
						blk_q       <= s_tdata[InBlkBit];
						res_ok_q    <= 1'b0;
						res_pick_q  <= '0;
						res_lvl_q   <= '0;
						res_moved_q <= '0;
						state_q     <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					unique case (op_q)
						OP_ADD: if (!queued) begin
							res_ok_q  <= 1'b1;
							res_lvl_q <= lv_add;
						end
						OP_REMOVE: if (queued) begin
							res_ok_q  <= 1'b1;
							res_lvl_q <= rd.prio;
						end
						OP_PICK: begin
							lv_q    <= TopLevel;
							state_q <= ST_PICK_LVL;
						end
						OP_REQUEUE: if (!queued) begin
							lv_q      <= lv_req;
							res_ok_q  <= 1'b1;
							res_lvl_q <= lv_req;
							state_q   <= ST_REQ_APP;
						end
						OP_SET_BLOCKED: if (queued) res_ok_q <= 1'b1;
						OP_TICK: begin
							tick_q   <= tick_q + 1'b1;
							res_ok_q <= 1'b1;
							if (boost_due) begin
								last_q  <= tick_q + 1'b1;
								lv_q    <= '0;
								state_q <= ST_BOOST_LVL;
							end
						end
						default: ;
					endcase
				end
				ST_REQ_APP: state_q <= ST_DONE;
				ST_PICK_LVL: begin
					if (rd.count != '0) begin
						cur_q   <= rd.head;
						k_q     <= rd.count;
						state_q <= ST_PICK_TASK;
					end else if (lv_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						lv_q <= lv_q - 1'b1;
					end
				end
				ST_PICK_TASK: begin
					if (!blkd) begin
						res_ok_q   <= 1'b1;
						res_pick_q <= cur_q;
						res_lvl_q  <= lv_q;
						state_q    <= ST_DONE;
					end else if (k_q == CntW'(1)) begin
						if (lv_q == '0) state_q <= ST_DONE;
						else begin
							lv_q    <= lv_q - 1'b1;
							state_q <= ST_PICK_LVL;
						end
					end else begin
						cur_q <= rd.next;
						k_q   <= k_q - 1'b1;
					end
				end
				ST_BOOST_LVL: begin
					if (rd.count != '0) begin
						cur_q   <= rd.head;
						k_q     <= rd.count;
						state_q <= ST_BOOST_UNL;
					end else if (lv_q == TopLevel - 1'b1) begin
						state_q <= ST_DONE;
					end else begin
						lv_q <= lv_q + 1'b1;
					end
				end
				ST_BOOST_UNL: begin
					nx_q <= rd.next;
					if (!idle) begin
						res_moved_q <= res_moved_q + 1'b1;
						state_q     <= ST_BOOST_APP;
					end else if (k_q == CntW'(1)) begin
						if (lv_q == TopLevel - 1'b1) state_q <= ST_DONE;
						else begin
							lv_q    <= lv_q + 1'b1;
							state_q <= ST_BOOST_LVL;
						end
					end else begin
						cur_q <= rd.next;
						k_q   <= k_q - 1'b1;
					end
				end
				ST_BOOST_APP: begin
					if (k_q == CntW'(1)) begin
						if (lv_q == TopLevel - 1'b1) state_q <= ST_DONE;
						else begin
							lv_q    <= lv_q + 1'b1;
							state_q <= ST_BOOST_LVL;
						end
					end else begin
						cur_q   <= nx_q;
						k_q     <= k_q - 1'b1;
						state_q <= ST_BOOST_UNL;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= OutDataW'({res_moved_q, res_lvl_q, res_pick_q, res_ok_q});
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MTS_ASSERT_NXT(a_result_loaded, (state_q == ST_DONE) && (!m_tvalid_q || m_tready), m_tvalid_q && (state_q == ST_IDLE), "finished result not loaded")
	`MTS_ASSERT_IMP(a_walk_count, (state_q == ST_PICK_TASK) || (state_q == ST_BOOST_UNL) || (state_q == ST_BOOST_APP), k_q != '0, "queue walk with empty count")
	`MTS_ASSERT_IMP(a_boost_low_levels, (state_q == ST_BOOST_LVL) || (state_q == ST_BOOST_UNL), lv_q != TopLevel, "boost walking the top level")

endmodule

@@ design/mlfq_task_scheduler.sv @@
// Channel   Dir  Payload (lowest bit first)                         Handshake
// s_*       in   operation, task_id, requested_level, idle_task,     s_tvalid & s_tready
//                ticks_used, blocked (29 bits in 32)
// m_*       out  ok, picked_task, task_level, moved_count (12 in 16) m_tvalid & m_tready
// wr_*      in   register index and 16-bit data                     wr_en
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Add, remove, set_blocked, undefined codes and a tick without boost run one execute step;
// requeue adds an append step. Pick visits levels from the top down and scans their tasks.
// A boosting tick visits the lower levels, checks each idle task once, and unlinks and
// appends each moved task; every step is one access of the shared queue table.
// A stalled result waits in the output register; the next item is accepted
// meanwhile and finishes once that register is free. Reset empties all queues.
module mlfq_task_scheduler
	import mts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // operation, task_id, requested_level, idle_task, ticks_used, blocked
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // ok, picked_task, task_level, moved_count
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [CfgW-1:0]     wr_data
);

	logic [CfgW-1:0] timeslice_q;
	logic [CfgW-1:0] boost_period_q;
	logic            boost_enable_q;
	tb_cmd_t         cmd;
	tb_rd_t          rd;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeslice_q    <= DefTimeslice;
			boost_period_q <= DefBoostInterval;
			boost_enable_q <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_TIMESLICE:      timeslice_q    <= wr_data;
				REG_BOOST_INTERVAL: boost_period_q <= wr_data;
				REG_BOOST_ENABLE:   boost_enable_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	mts_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.timeslice    (timeslice_q),
		.boost_period (boost_period_q),
		.boost_enable (boost_enable_q),
		.cmd          (cmd),
		.rd           (rd)
	);

	mts_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd     (rd)
	);

endmodule

@@ tb/mlfq_task_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the register port, runs a scheduler model and
// compares every result item with the oldest predicted one.
module mlfq_task_checker
	import mts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OutDataW-1:0] m_tdata,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [CfgW-1:0]     wr_data,
	output int                  err_count,
	output int                  pending,
	output logic [NumTasks-1:0] queued_mask
);

	// Packed from the top bit down: ok lands in bit 0
	typedef struct packed {
		logic [4:0]      moved;
		logic [LvlW-1:0] level;
		logic [TidW-1:0] picked;
		logic            ok;
	} sched_res_t;

	sched_res_t sched_q[$];

	logic [CfgW-1:0]  slice_len;
	logic [CfgW-1:0]  boost_gap;
	logic             boost_on;
	logic [TidW-1:0]  nxt[NumTasks];
	logic [TidW-1:0]  prv[NumTasks];
	logic [LvlW-1:0]  prio[NumTasks];
	logic [FlagW-1:0] flg[NumTasks];
	logic [TidW-1:0]  head[NumLevels];
	logic [TidW-1:0]  tail[NumLevels];
	int               cnt[NumLevels];
	logic [TickW-1:0] ticks;
	logic [TickW-1:0] boost_mark;

	assign pending = sched_q.size();
	always_comb
		for (int i = 0; i < NumTasks; i++)
			queued_mask[i] = flg[i][FlagQueued];

	function automatic void link_tail(int t, int lv);
		if (cnt[lv] == 0) begin
			head[lv] = TidW'(t);
		end else begin
			nxt[tail[lv]] = TidW'(t);
			prv[t] = tail[lv];
		end
		tail[lv] = TidW'(t);
		cnt[lv]++;
		prio[t] = LvlW'(lv);
		flg[t] |= QueuedMask;
	endfunction

	function automatic void unlink(int t);
		int lv;
		bit at_head, at_tail;
		lv = prio[t];
		at_head = (head[lv] == TidW'(t));
		at_tail = (tail[lv] == TidW'(t));
		if (at_head)
			head[lv] = nxt[t];
		else
			nxt[prv[t]] = nxt[t];
		if (at_tail)
			tail[lv] = prv[t];
		else
			prv[nxt[t]] = prv[t];
		if (cnt[lv] > 0)
			cnt[lv]--;
		flg[t] &= ~QueuedMask;
	endfunction

	// Move every non-idle task of the lower levels to the top level.
	function automatic int boost_lower();
		int moved, n, cur, nx;
		moved = 0;
		for (int lv = 0; lv < NumLevels - 1; lv++) begin
			n = cnt[lv];
			cur = head[lv];
			for (int k = 0; k < n; k++) begin
				nx = nxt[cur];
				if (!flg[cur][FlagIdle]) begin
					unlink(cur);
					link_tail(cur, NumLevels - 1);
					moved++;
				end
				cur = nx;
			end
		end
		return moved;
	endfunction

	function automatic sched_res_t schedule(logic [InDataW-1:0] d);
		sched_res_t r;
		logic [2:0]      op;
		int              t, lv, n, cur;
		logic [3:0]      rl;
		logic            idle, blk;
		logic [15:0]     used;
		r = '0;
		op = d[InOpLsb +: 3];
		t = d[InTidLsb +: TidW];
		rl = d[InRlLsb +: 4];
		idle = d[InIdleBit];
		used = d[InUsedLsb +: 16];
		blk = d[InBlkBit];
		case (op)
			OP_ADD: begin
				if (!flg[t][FlagQueued]) begin
					if (rl[3])
						lv = 0;
					else
						lv = (rl > NumLevels - 1) ? NumLevels - 1 : rl;
					flg[t] = idle ? IdleMask : '0;
					link_tail(t, lv);
					r.ok = 1;
					r.level = LvlW'(lv);
				end
			end
			OP_REMOVE: begin
				if (flg[t][FlagQueued]) begin
					r.level = prio[t];
					unlink(t);
					r.ok = 1;
				end
			end
			OP_PICK: begin
				// scan top level first, head to tail; skip blocked tasks
				for (lv = NumLevels - 1; lv >= 0 && !r.ok; lv--) begin
					n = cnt[lv];
					cur = head[lv];
					for (int k = 0; k < n; k++) begin
						if (!flg[cur][FlagBlocked]) begin
							unlink(cur);
							r.ok = 1;
							r.picked = TidW'(cur);
							r.level = LvlW'(lv);
							break;
						end
						cur = nxt[cur];
					end
				end
			end
			OP_REQUEUE: begin
				if (!flg[t][FlagQueued]) begin
					lv = prio[t];
					if (used >= slice_len && lv > 0)
						lv--;
					flg[t] = (flg[t] & IdleMask) | (blk ? BlockedMask : '0);
					link_tail(t, lv);
					r.ok = 1;
					r.level = LvlW'(lv);
				end
			end
			OP_SET_BLOCKED: begin
				if (flg[t][FlagQueued]) begin
					flg[t] = (flg[t] & ~BlockedMask) | (blk ? BlockedMask : '0);
					r.ok = 1;
				end
			end
			OP_TICK: begin
				ticks++;
				if (boost_on && (ticks - boost_mark) > TickW'(boost_gap)) begin
					boost_mark = ticks;
					r.moved = 5'(boost_lower());
				end
				r.ok = 1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Track registers, predict on each input item, check each result item.
	always @(posedge clk or negedge arst_n) begin
		sched_res_t got, want;
		if (!arst_n) begin
			slice_len = DefTimeslice;
			boost_gap = DefBoostInterval;
			boost_on = 1;
			for (int i = 0; i < NumTasks; i++) begin
				nxt[i] = '0;
				prv[i] = '0;
				prio[i] = '0;
				flg[i] = '0;
			end
			for (int i = 0; i < NumLevels; i++) begin
				head[i] = '0;
				tail[i] = '0;
				cnt[i] = 0;
			end
			ticks = '0;
			boost_mark = '0;
			sched_q.delete();
			err_count = 0;
		end else begin
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_TIMESLICE:      slice_len = wr_data;
					REG_BOOST_INTERVAL: boost_gap = wr_data;
					REG_BOOST_ENABLE:   boost_on = wr_data[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[11:0];
				if (sched_q.size() == 0) begin
					$error("result item with nothing expected: %h", m_tdata);
					err_count++;
				end else begin
					want = sched_q.pop_front();
					if (got.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, got.ok);
						err_count++;
					end
					if (got.picked !== want.picked) begin
						$error("picked_task: expected %0d, got %0d", want.picked, got.picked);
						err_count++;
					end
					if (got.level !== want.level) begin
						$error("task_level: expected %0d, got %0d", want.level, got.level);
						err_count++;
					end
					if (got.moved !== want.moved) begin
						$error("moved_count: expected %0d, got %0d", want.moved, got.moved);
						err_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				sched_q.push_back(schedule(s_tdata));
		end
	end

endmodule

@@ tb/tb_mlfq_task_scheduler.sv @@
`timescale 1ns / 1ps

module tb_mlfq_task_scheduler;
	import mts_pkg::*;

	localparam logic [2:0] OP_UNDEF_A = 3'd6;
	localparam logic [2:0] OP_UNDEF_B = 3'd7;
	localparam int CycleLimit = 1000000;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;    // operation, task_id, requested_level, idle_task, ticks_used, blocked
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;    // ok, picked_task, task_level, moved_count
	logic                wr_en;
	logic [1:0]          wr_index;
	logic [CfgW-1:0]     wr_data;
	int                  err_count;
	int                  pending;
	logic [NumTasks-1:0] queued_mask;
	logic [NumTasks-1:0] ever_added;
	bit                  hold_req;
	bit                  no_gaps;
	int                  cycles;

	mlfq_task_scheduler u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	mlfq_task_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.err_count(err_count), .pending(pending), .queued_mask(queued_mask)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// Abort a hung run.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off on request.
	initial begin
		int mode;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 0;
				repeat (500) @(posedge clk);
				hold_req = 0;
			end
			mode = $urandom_range(0, 9);
			if (no_gaps || mode < 6) begin
				m_tready <= 1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else if (mode < 9) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				m_tready <= 0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	task automatic send_item(logic [2:0] op, int tid, logic [3:0] rl, bit idle,
			logic [15:0] used, bit blk);
		int mode;
		s_tvalid <= 1;
		s_tdata <= {3'b0, blk, used, idle, rl, TidW'(tid), op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_ADD)
			ever_added[tid] = 1;
		mode = $urandom_range(0, 19);
		if (!no_gaps && mode >= 10) begin
			s_tvalid <= 0;
			repeat (mode < 17 ? $urandom_range(1, 3) : $urandom_range(5, 30))
				@(posedge clk);
		end
	endtask

	// Hold input until every result has come back.
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] slice, logic [15:0] gap, bit en);
		drain();
		wr_en <= 1;
		wr_index <= REG_TIMESLICE;
		wr_data <= slice;
		@(posedge clk);
		wr_index <= REG_BOOST_INTERVAL;
		wr_data <= gap;
		@(posedge clk);
		wr_index <= REG_BOOST_ENABLE;
		wr_data <= CfgW'(en);
		@(posedge clk);
		wr_en <= 0;
	endtask

	function automatic int pick_from(logic [NumTasks-1:0] m);
		int start;
		start = $urandom_range(0, NumTasks - 1);
		for (int i = 0; i < NumTasks; i++)
			if (m[(start + i) % NumTasks])
				return (start + i) % NumTasks;
		return -1;
	endfunction

	function automatic logic [15:0] rand_used();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 8));
			default: return 16'($urandom);
		endcase
	endfunction

	// One random operation, mostly on tasks in a state where it succeeds.
	task automatic rand_item();
		int w, tid, alt;
		logic [2:0] op;
		w = $urandom_range(0, 99);
		tid = $urandom_range(0, NumTasks - 1);
		if (w < 25) begin
			op = OP_ADD;
			alt = pick_from(~queued_mask);
			if (alt >= 0 && $urandom_range(0, 3) != 0) tid = alt;
		end else if (w < 33) begin
			op = OP_REMOVE;
			alt = pick_from(queued_mask);
			if (alt >= 0 && $urandom_range(0, 3) != 0) tid = alt;
		end else if (w < 55) begin
			op = OP_PICK;
		end else if (w < 75) begin
			op = OP_REQUEUE;
			alt = pick_from(ever_added & ~queued_mask);
			if (alt < 0 || $urandom_range(0, 7) == 0)
				alt = pick_from(ever_added);
			if (alt < 0)
				op = OP_ADD;
			else
				tid = alt;
		end else if (w < 85) begin
			op = OP_SET_BLOCKED;
			alt = pick_from(queued_mask);
			if (alt >= 0 && $urandom_range(0, 3) != 0) tid = alt;
		end else if (w < 97) begin
			op = OP_TICK;
		end else begin
			op = $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
		end
		send_item(op, tid, 4'($urandom), ($urandom_range(0, 3) == 0),
			rand_used(), $urandom_range(0, 2) == 0);
	endtask

	task automatic rand_phase(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			rand_item();
		end
		no_gaps = 0;
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		wr_en = 0;
		wr_index = REG_TIMESLICE;
		wr_data = '0;
		ever_added = '0;
		hold_req = 0;
		no_gaps = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: clamping, idle and blocked tasks, demotion, boost, bad codes.
		set_regs(16'd1, 16'd0, 1);
		send_item(OP_ADD, 0, 4'b1000, 0, 16'h0000, 0);
		send_item(OP_ADD, 1, 4'b0111, 0, 16'hFFFF, 1);
		send_item(OP_ADD, 2, 4'b0001, 1, 16'h0000, 0);
		send_item(OP_ADD, 15, 4'b0010, 0, 16'h0000, 0);
		send_item(OP_ADD, 1, 4'b0000, 0, 16'h0000, 0);
		send_item(OP_SET_BLOCKED, 1, 4'b0, 0, 16'h0, 1);
		send_item(OP_SET_BLOCKED, 5, 4'b0, 0, 16'h0, 1);
		send_item(OP_PICK, 0, 4'b0, 0, 16'h0, 0);
		send_item(OP_REQUEUE, 15, 4'b0, 0, 16'hFFFF, 0);
		send_item(OP_REQUEUE, 1, 4'b0, 0, 16'h0, 0);
		send_item(OP_PICK, 0, 4'b0, 0, 16'h0, 0);
		send_item(OP_REQUEUE, 0, 4'b0, 0, 16'hFFFF, 1);
		send_item(OP_TICK, 0, 4'b0, 0, 16'h0, 0);
		send_item(OP_REMOVE, 2, 4'b0, 0, 16'h0, 0);
		send_item(OP_REMOVE, 2, 4'b0, 0, 16'h0, 0);
		send_item(OP_UNDEF_A, 3, 4'b1111, 1, 16'hFFFF, 1);
		send_item(OP_UNDEF_B, 0, 4'b0, 0, 16'h0, 0);
		send_item(OP_SET_BLOCKED, 1, 4'b0, 0, 16'h0, 0);
		repeat (5) send_item(OP_PICK, 0, 4'b0, 0, 16'h0, 0);

		// Random phases over several register settings.
		set_regs(16'd1, 16'd10, 1);
		rand_phase(170);
		set_regs(16'hFFFF, 16'hFFFF, 1);
		rand_phase(170);
		set_regs(16'd3, 16'd0, 0);
		rand_phase(170);
		set_regs(16'd5, 16'd2, 1);
		hold_req = 1;
		rand_phase(170);
		set_regs(16'd1, 16'd0, 1);
		rand_phase(170);
		set_regs(16'd2, 16'd1, 1);
		rand_phase(170);

		drain();
		repeat (100) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
